// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the relocation patch block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside of reset
`define AREL_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define AREL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/arel_pkg.sv =====
// ----------------------------------------------------------------------------
// arel_pkg
// types, codes and decode helpers for the ARM ELF32 relocation patcher
// ----------------------------------------------------------------------------
package arel_pkg;

	// relocation type codes
	localparam logic [7:0] KIND_NONE       = 8'd0;
	localparam logic [7:0] KIND_PC24       = 8'd1;
	localparam logic [7:0] KIND_ABS32      = 8'd2;
	localparam logic [7:0] KIND_REL32      = 8'd3;
	localparam logic [7:0] KIND_THM_CALL   = 8'd10;
	localparam logic [7:0] KIND_GLOB_DAT   = 8'd21;
	localparam logic [7:0] KIND_JUMP_SLOT  = 8'd22;
	localparam logic [7:0] KIND_RELATIVE   = 8'd23;
	localparam logic [7:0] KIND_PLT32      = 8'd27;
	localparam logic [7:0] KIND_CALL       = 8'd28;
	localparam logic [7:0] KIND_JUMP24     = 8'd29;
	localparam logic [7:0] KIND_THM_JUMP24 = 8'd30;
	localparam logic [7:0] KIND_V4BX       = 8'd40;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNSUPP    = 2'd1;
	localparam logic [1:0] ST_THUMB_BAD = 2'd2;

	// register map
	localparam int unsigned ADDR_W = 3;
	localparam logic REG_LOAD_BASE = 1'b0;
	localparam logic REG_LINK_BASE = 1'b1;

	// patch constants
	localparam logic [31:0] V4BX_KEEP   = 32'hf000000f;
	localparam logic [31:0] V4BX_SET    = 32'h01a0f000;
	localparam logic [31:0] THM_BIAS    = 32'h00ffffff;
	localparam logic [31:0] THM_SPAN    = 32'h01fffffe;

	typedef enum logic [3:0] {
		CLS_NONE,
		CLS_ABS,
		CLS_REL,
		CLS_ARM24,
		CLS_V4BX,
		CLS_GOT,
		CLS_RELATIVE,
		CLS_THUMB,
		CLS_UNSUPP
	} cls_t;

	typedef struct packed {
		logic [31:0] load_base;
		logic [31:0] link_base;
	} cfg_t;

	// map a type code to its patch class
	function automatic cls_t decode_kind(input logic [7:0] kind);
		cls_t cls;
		case (kind) inside
			KIND_NONE: cls = CLS_NONE;
			KIND_ABS32: cls = CLS_ABS;
			KIND_REL32: cls = CLS_REL;
			KIND_PC24, KIND_PLT32, KIND_CALL, KIND_JUMP24: cls = CLS_ARM24;
			KIND_V4BX: cls = CLS_V4BX;
			KIND_GLOB_DAT, KIND_JUMP_SLOT: cls = CLS_GOT;
			KIND_RELATIVE: cls = CLS_RELATIVE;
			KIND_THM_CALL, KIND_THM_JUMP24: cls = CLS_THUMB;
			default: cls = CLS_UNSUPP;
		endcase
		return cls;
	endfunction

	// decode the 25-bit thumb branch offset, sign extended
	function automatic logic [31:0] thumb_offset(input logic [31:0] word);
		logic s;
		logic i1;
		logic i2;
		s = word[10];
		i1 = ~(word[29] ^ s);
		i2 = ~(word[27] ^ s);
		return {{7{s}}, s, i1, i2, word[9:0], word[26:16], 1'b0};
	endfunction

endpackage

// ===== design/arel_if.sv =====
// ----------------------------------------------------------------------------
// arel_if
// valid/ready channels for relocation items and patch results
// ----------------------------------------------------------------------------
interface arel_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  kind;
	logic [31:0] rel_offset;
	logic [31:0] symbol_value;
	logic [31:0] old_word;

	modport source (output valid, kind, rel_offset, symbol_value, old_word, input ready);
	modport sink (input valid, kind, rel_offset, symbol_value, old_word, output ready);
endinterface

interface arel_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] new_word;
	logic        write_back;
	logic [1:0]  status;

	modport source (output valid, new_word, write_back, status, input ready);
	modport sink (input valid, new_word, write_back, status, output ready);
endinterface

// ===== design/arm_elf_relocation_patch_top.sv =====
// ----------------------------------------------------------------------------
// arm_elf_relocation_patch_top
// ARM ELF32 relocation patcher: APB base registers plus patch pipeline
// ----------------------------------------------------------------------------
// Each relocation item on req yields exactly one result on rsp, and a new item
// is taken in every cycle while rsp is ready; the patch pipeline has four
// register stages (place address, S - P, branch sums, encode and result
// register). Stalls on rsp back up stage by stage without losing items.
// load_base (byte address 0) and link_base (byte address 4) are to be written
// over APB by the user only while no item is in flight; the block itself does
// not enforce this.

module arm_elf_relocation_patch_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [arel_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	arel_in_if.sink                       req,
	arel_out_if.source                    rsp
);

	arel_pkg::cfg_t cfg;

	// base address registers
	arel_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// patch pipeline
	arel_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// ===== design/arel_regs.sv =====
// ----------------------------------------------------------------------------
// arel_regs
// APB register file holding the load and link base addresses
// ----------------------------------------------------------------------------
module arel_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [arel_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output arel_pkg::cfg_t                cfg
);

	logic [31:0] load_base_q;
	logic [31:0] link_base_q;
	logic        wr_en;
	logic        reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel & penable & pwrite & pready;

	// register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_base_q <= '0;
			link_base_q <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				arel_pkg::REG_LOAD_BASE: load_base_q <= pwdata;
				arel_pkg::REG_LINK_BASE: link_base_q <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_sel)
			arel_pkg::REG_LOAD_BASE: prdata = load_base_q;
			arel_pkg::REG_LINK_BASE: prdata = link_base_q;
			default: prdata = '0;
		endcase
	end

	assign cfg.load_base = load_base_q;
	assign cfg.link_base = link_base_q;

endmodule

// ===== design/arel_core.sv =====
// ----------------------------------------------------------------------------
// arel_core
// four-stage relocation patch pipeline with per-stage valid and stall
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arel_core (
	input  logic            clk,
	input  logic            arst_n,
	input  arel_pkg::cfg_t  cfg,
	arel_in_if.sink         req,
	arel_out_if.source      rsp
);

	// stage valids and stage acceptance
	logic v1_s1;
	logic v2_s2;
	logic v3_s3;
	logic v4_s4;
	logic rdy1;
	logic rdy2;
	logic rdy3;
	logic rdy4;

	// stage 1 payload
	arel_pkg::cls_t cls_s1;
	logic [31:0]    sym_s1;
	logic [31:0]    word_s1;
	logic [31:0]    place_s1;

	// stage 2 payload
	arel_pkg::cls_t cls_s2;
	logic [31:0]    sym_s2;
	logic [31:0]    word_s2;
	logic [31:0]    smp_s2;
	logic [31:0]    wsum_s2;
	logic [31:0]    arm_add_s2;
	logic [31:0]    thm_off_s2;

	// stage 3 payload
	arel_pkg::cls_t cls_s3;
	logic [31:0]    sym_s3;
	logic [31:0]    word_s3;
	logic [31:0]    wsum_s3;
	logic [31:0]    rel_s3;
	logic [31:0]    arm_sum_s3;
	logic [31:0]    thm_sum_s3;

	// stage 4 result register
	logic [31:0] new_word_s4;
	logic        wb_s4;
	logic [1:0]  status_s4;

	// final stage combinational result
	logic [31:0] thm_chk;
	logic        thm_ok;
	logic        ns;
	logic        j1;
	logic        j2;
	logic [31:0] thm_word;
	logic [31:0] res_d;
	logic        wb_d;
	logic [1:0]  st_d;

	// a stage takes a new item when empty or when its item moves on
	assign rdy4      = ~v4_s4 | rsp.ready;
	assign rdy3      = ~v3_s3 | rdy4;
	assign rdy2      = ~v2_s2 | rdy3;
	assign rdy1      = ~v1_s1 | rdy2;
	assign req.ready = rdy1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (rdy1) v1_s1 <= req.valid;
			if (rdy2) v2_s2 <= v1_s1;
			if (rdy3) v3_s3 <= v2_s2;
			if (rdy4) v4_s4 <= v3_s3;
		end
	end

	// stage 1: decode type, runtime place address
	always_ff @(posedge clk) begin
		if (rdy1 && req.valid) begin
			cls_s1   <= arel_pkg::decode_kind(req.kind);
			sym_s1   <= req.symbol_value;
			word_s1  <= req.old_word;
			place_s1 <= cfg.load_base + req.rel_offset - cfg.link_base;
		end
	end

	// stage 2: S - P, word + S, arm addend, thumb offset decode
	always_ff @(posedge clk) begin
		if (rdy2 && v1_s1) begin
			cls_s2     <= cls_s1;
			sym_s2     <= sym_s1;
			word_s2    <= word_s1;
			smp_s2     <= sym_s1 - place_s1;
			wsum_s2    <= word_s1 + sym_s1;
			arm_add_s2 <= {{6{word_s1[23]}}, word_s1[23:0], 2'b00};
			thm_off_s2 <= arel_pkg::thumb_offset(word_s1);
		end
	end

	// stage 3: pc-relative sums
	always_ff @(posedge clk) begin
		if (rdy3 && v2_s2) begin
			cls_s3     <= cls_s2;
			sym_s3     <= sym_s2;
			word_s3    <= word_s2;
			wsum_s3    <= wsum_s2;
			rel_s3     <= word_s2 + smp_s2;
			arm_sum_s3 <= smp_s2 + arm_add_s2;
			thm_sum_s3 <= thm_off_s2 + smp_s2;
		end
	end

	// thumb range check and re-encode
	always_comb begin
		thm_chk  = thm_sum_s3 + arel_pkg::THM_BIAS;
		thm_ok   = thm_sum_s3[0] && (thm_chk <= arel_pkg::THM_SPAN);
		ns       = thm_sum_s3[24];
		j1       = ns ^ ~thm_sum_s3[23];
		j2       = ns ^ ~thm_sum_s3[22];
		thm_word = {word_s3[31:30], j1, word_s3[28], j2, thm_sum_s3[11:1],
			word_s3[15:11], ns, thm_sum_s3[21:12]};
	end

	// result select per class
	always_comb begin
		res_d = word_s3;
		wb_d  = 1'b1;
		st_d  = arel_pkg::ST_OK;
		case (cls_s3)
			arel_pkg::CLS_NONE: wb_d = 1'b0;
			arel_pkg::CLS_ABS: res_d = wsum_s3;
			arel_pkg::CLS_REL: res_d = rel_s3;
			arel_pkg::CLS_ARM24: res_d = {word_s3[31:24], arm_sum_s3[25:2]};
			arel_pkg::CLS_V4BX: res_d = (word_s3 & arel_pkg::V4BX_KEEP) | arel_pkg::V4BX_SET;
			arel_pkg::CLS_GOT: res_d = sym_s3;
			arel_pkg::CLS_RELATIVE: res_d = wsum_s3;
			arel_pkg::CLS_THUMB: begin
				if (thm_ok) begin
					res_d = thm_word;
				end else begin
					wb_d = 1'b0;
					st_d = arel_pkg::ST_THUMB_BAD;
				end
			end
			default: begin
				wb_d = 1'b0;
				st_d = arel_pkg::ST_UNSUPP;
			end
		endcase
	end

	// stage 4: output register
	always_ff @(posedge clk) begin
		if (rdy4 && v3_s3) begin
			new_word_s4 <= res_d;
			wb_s4       <= wb_d;
			status_s4   <= st_d;
		end
	end

	assign rsp.valid      = v4_s4;
	assign rsp.new_word   = new_word_s4;
	assign rsp.write_back = wb_s4;
	assign rsp.status     = status_s4;

	// checks
	`AREL_ASSERT(a_stall_holds_s1, clk, arst_n, v1_s1 && !rdy2 |=> v1_s1, "stage 1 item dropped on stall")
	`AREL_ASSERT(a_unsupp_status, clk, arst_n, v3_s3 && rdy4 && cls_s3 == arel_pkg::CLS_UNSUPP |=> rsp.status == arel_pkg::ST_UNSUPP && !rsp.write_back, "unsupported type not flagged")
	`AREL_ASSERT(a_thumb_status_only, clk, arst_n, v3_s3 && rdy4 && cls_s3 != arel_pkg::CLS_THUMB |=> rsp.status != arel_pkg::ST_THUMB_BAD, "thumb error on non-thumb item")
	`AREL_ASSERT(a_wb_means_ok, clk, arst_n, rsp.valid && rsp.write_back |-> rsp.status == arel_pkg::ST_OK, "write back with error status")

endmodule
